// ----- rtl/core/rhc_pkg.sv -----
// shared constants and types for the rgb/hsl color converter
package rhc_pkg;

    localparam int FIELD_W = 8;

    typedef enum logic
    {
        DIR_RGB2HSL = 1'b0,
        DIR_HSL2RGB = 1'b1
    } dir_t;

endpackage

// ----- rtl/core/rhc_div.sv -----
// pipelined restoring divider, one quotient bit per stage, quotient = (num << (QB-1)) / den
module rhc_div
#(
    parameter int NW = 18,
    parameter int QB = 17
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    output logic [QB-1:0] quo
);

    logic [NW:0]   rem_reg [QB];
    logic [NW-1:0] den_reg [QB];
    logic [QB-1:0] quo_reg [QB];

    for (genvar i = 0; i < QB; i++)
    begin : g_step
        logic [NW:0]   trial;
        logic [NW-1:0] den_cur;
        logic [QB-1:0] quo_prev;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign trial    = {1'b0, num};
            assign den_cur  = den;
            assign quo_prev = '0;
        end
        else
        begin : g_rest
            assign trial    = {rem_reg[i-1][NW-1:0], 1'b0};
            assign den_cur  = den_reg[i-1];
            assign quo_prev = quo_reg[i-1];
        end

        assign ge = (trial >= {1'b0, den_cur});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? (trial - {1'b0, den_cur}) : trial;
                den_reg[i] <= den_cur;
                quo_reg[i] <= {quo_prev[QB-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[QB-1];

endmodule

// ----- rtl/core/rhc_to_hsl.sv -----
// rgb to hsl datapath on fixed-point fractions
module rhc_to_hsl
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               en,
    input  logic [FRAC_BITS:0] red,
    input  logic [FRAC_BITS:0] green,
    input  logic [FRAC_BITS:0] blue,
    output logic [FRAC_BITS:0] hue,
    output logic [FRAC_BITS:0] sat,
    output logic [FRAC_BITS:0] lig
);

    localparam int W  = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 2;
    localparam int HW = FRAC_BITS + 3;
    localparam int QB = FRAC_BITS + 1;
    localparam int BW = W + 5;
    localparam logic [W-1:0]  ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [W-1:0]  HALF   = ONE >> 1;
    localparam logic [SW-1:0] TWO    = {2'b10, {FRAC_BITS{1'b0}}};
    localparam logic [SW-1:0] RECIP3 = SW'((64'd1 << SW) / 3);

    typedef enum logic [1:0]
    {
        SEL_R = 2'd0,
        SEL_G = 2'd1,
        SEL_B = 2'd2
    } sel_t;

    // stage a: max and min
    logic [W-1:0] a_r_reg, a_g_reg, a_b_reg, a_mx_reg, a_mn_reg;
    sel_t         a_sel_reg;
    logic [W-1:0] mx_next, mn_next;
    sel_t         sel_next;

    always_comb
    begin
        mx_next  = red;
        mn_next  = red;
        sel_next = SEL_R;
        if (green > mx_next)
        begin
            mx_next  = green;
            sel_next = SEL_G;
        end
        if (blue > mx_next)
        begin
            mx_next  = blue;
            sel_next = SEL_B;
        end
        if (green < mn_next)
        begin
            mn_next = green;
        end
        if (blue < mn_next)
        begin
            mn_next = blue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_r_reg   <= red;
            a_g_reg   <= green;
            a_b_reg   <= blue;
            a_mx_reg  <= mx_next;
            a_mn_reg  <= mn_next;
            a_sel_reg <= sel_next;
        end
    end

    // stage b: lightness, divider operands, hue sector
    logic [SW-1:0] sum;
    logic [W-1:0]  l_next, d_next, hn_next;
    logic [SW-1:0] sden_next;
    logic [2:0]    base_next;
    logic          neg_next;
    logic [SW-1:0] b_snum_reg, b_sden_reg, b_hnum_reg, b_hden_reg;
    logic [BW-1:0] b_side_reg;

    always_comb
    begin
        sum       = {1'b0, a_mx_reg} + {1'b0, a_mn_reg};
        l_next    = sum[SW-1:1];
        d_next    = a_mx_reg - a_mn_reg;
        sden_next = (l_next > HALF) ? (TWO - sum) : sum;
        hn_next   = '0;
        neg_next  = 1'b0;
        base_next = 3'd0;
        case (a_sel_reg)
            SEL_G:
            begin
                base_next = 3'd2;
                neg_next  = (a_b_reg < a_r_reg);
                hn_next   = neg_next ? (a_r_reg - a_b_reg) : (a_b_reg - a_r_reg);
            end
            SEL_B:
            begin
                base_next = 3'd4;
                neg_next  = (a_r_reg < a_g_reg);
                hn_next   = neg_next ? (a_g_reg - a_r_reg) : (a_r_reg - a_g_reg);
            end
            default:
            begin
                neg_next  = (a_g_reg < a_b_reg);
                base_next = neg_next ? 3'd6 : 3'd0;
                hn_next   = neg_next ? (a_b_reg - a_g_reg) : (a_g_reg - a_b_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_snum_reg <= {1'b0, d_next};
            b_sden_reg <= sden_next;
            b_hnum_reg <= {1'b0, hn_next};
            b_hden_reg <= {1'b0, d_next};
            b_side_reg <= {neg_next, base_next, (a_mx_reg == a_mn_reg), l_next};
        end
    end

    // dividers with the side fields traveling alongside
    logic [QB-1:0] s_quo, h_quo;
    logic [BW-1:0] side_reg [QB];

    rhc_div #(.NW(SW), .QB(QB)) u_sdiv
    (
        .clk (clk),
        .en  (en),
        .num (b_snum_reg),
        .den (b_sden_reg),
        .quo (s_quo)
    );

    rhc_div #(.NW(SW), .QB(QB)) u_hdiv
    (
        .clk (clk),
        .en  (en),
        .num (b_hnum_reg),
        .den (b_hden_reg),
        .quo (h_quo)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= b_side_reg;
            for (int i = 1; i < QB; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // stage c: hue times six
    logic [HW-1:0] base_full, h6_next;
    logic [HW-1:0] c_h6_reg;
    logic [W-1:0]  c_s_reg, c_l_reg;
    logic          c_grey_reg;

    always_comb
    begin
        base_full = {side_reg[QB-1][BW-2 -: 3], {FRAC_BITS{1'b0}}};
        h6_next   = side_reg[QB-1][BW-1] ? (base_full - HW'(h_quo))
                                         : (base_full + HW'(h_quo));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_h6_reg   <= h6_next;
            c_s_reg    <= (s_quo > ONE) ? ONE : s_quo;
            c_l_reg    <= side_reg[QB-1][W-1:0];
            c_grey_reg <= side_reg[QB-1][W];
        end
    end

    // stage d: divide by six as a halving and a reciprocal multiply by three
    logic [SW-1:0]   d_x_reg;
    logic [2*SW-1:0] d_prod_reg;
    logic [W-1:0]    d_s_reg, d_l_reg;
    logic            d_grey_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_x_reg    <= c_h6_reg[HW-1:1];
            d_prod_reg <= {{SW{1'b0}}, c_h6_reg[HW-1:1]} * {{SW{1'b0}}, RECIP3};
            d_s_reg    <= c_s_reg;
            d_l_reg    <= c_l_reg;
            d_grey_reg <= c_grey_reg;
        end
    end

    // stage e: quotient correction
    logic [SW-1:0] q0, rem3, h_full;
    logic [W-1:0]  hue_reg, sat_reg, lig_reg;

    always_comb
    begin
        q0     = d_prod_reg[2*SW-1 -: SW];
        rem3   = d_x_reg - {q0[SW-2:0], 1'b0} - q0;
        h_full = q0 + SW'(rem3 >= SW'(3));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d_grey_reg)
            begin
                hue_reg <= '0;
                sat_reg <= '0;
            end
            else
            begin
                hue_reg <= (h_full > {1'b0, ONE}) ? ONE : h_full[W-1:0];
                sat_reg <= d_s_reg;
            end
            lig_reg <= d_l_reg;
        end
    end

    assign hue = hue_reg;
    assign sat = sat_reg;
    assign lig = lig_reg;

endmodule

// ----- rtl/core/rhc_to_rgb.sv -----
// hsl to rgb datapath on fixed-point fractions
module rhc_to_rgb
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               en,
    input  logic [FRAC_BITS:0] hue,
    input  logic [FRAC_BITS:0] sat,
    input  logic [FRAC_BITS:0] lig,
    output logic [FRAC_BITS:0] red,
    output logic [FRAC_BITS:0] green,
    output logic [FRAC_BITS:0] blue
);

    localparam int W  = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 2;
    localparam int MW = FRAC_BITS + 3;
    localparam int PW = W + MW;
    localparam logic [W-1:0] ONE        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [W-1:0] HALF       = ONE >> 1;
    localparam logic [W-1:0] SIXTH      = W'((64'd1 << FRAC_BITS) / 6);
    localparam logic [W-1:0] THIRD      = W'((64'd1 << FRAC_BITS) / 3);
    localparam logic [W-1:0] TWO_THIRDS = W'((64'd2 << FRAC_BITS) / 3);

    typedef enum logic [1:0]
    {
        SEG_RAMP = 2'd0,
        SEG_Q    = 2'd1,
        SEG_P    = 2'd2
    } seg_t;

    // stage a: l * s
    logic [2*W-1:0] a_ls_reg;
    logic [W-1:0]   a_h_reg, a_s_reg, a_l_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ls_reg <= {{W{1'b0}}, lig} * {{W{1'b0}}, sat};
            a_h_reg  <= hue;
            a_s_reg  <= sat;
            a_l_reg  <= lig;
        end
    end

    // stage b: q, p and the three hue offsets
    logic [W-1:0]  lsf, q_next, p_next;
    logic [SW-1:0] q_raw, l2, th0;
    logic [W-1:0]  u_next [3];
    logic [W-1:0]  b_p_reg, b_q_reg, b_span_reg, b_l_reg;
    logic [W-1:0]  b_u_reg [3];
    logic          b_grey_reg;

    always_comb
    begin
        lsf    = a_ls_reg[FRAC_BITS +: W];
        q_raw  = (a_l_reg < HALF) ? ({1'b0, a_l_reg} + {1'b0, lsf})
                                  : ({1'b0, a_l_reg} + {1'b0, a_s_reg} - {1'b0, lsf});
        q_next = (q_raw > {1'b0, ONE}) ? ONE : q_raw[W-1:0];
        l2     = {a_l_reg, 1'b0};
        if (l2 > {1'b0, q_next})
        begin
            p_next = ((l2 - {1'b0, q_next}) > {1'b0, ONE}) ? ONE
                                                           : W'(l2 - {1'b0, q_next});
        end
        else
        begin
            p_next = '0;
        end
        th0       = {1'b0, a_h_reg} + {1'b0, THIRD};
        u_next[0] = (th0 > {1'b0, ONE}) ? W'(th0 - {1'b0, ONE}) : th0[W-1:0];
        u_next[1] = a_h_reg;
        u_next[2] = (a_h_reg >= THIRD) ? (a_h_reg - THIRD) : (a_h_reg + (ONE - THIRD));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_p_reg    <= p_next;
            b_q_reg    <= q_next;
            b_span_reg <= (q_next > p_next) ? (q_next - p_next) : '0;
            b_l_reg    <= a_l_reg;
            b_grey_reg <= (a_s_reg == '0);
            for (int k = 0; k < 3; k++)
            begin
                b_u_reg[k] <= u_next[k];
            end
        end
    end

    // stage c: segment of the hue curve and the ramp multiplier
    seg_t          seg_next [3];
    logic [MW-1:0] m_next   [3];
    logic [W-1:0]  ramp_tail;
    seg_t          c_seg_reg [3];
    logic [MW-1:0] c_m_reg   [3];
    logic [W-1:0]  c_p_reg, c_q_reg, c_span_reg, c_l_reg;
    logic          c_grey_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ramp_tail   = TWO_THIRDS - b_u_reg[k];
            seg_next[k] = SEG_P;
            m_next[k]   = '0;
            if (b_u_reg[k] < SIXTH)
            begin
                seg_next[k] = SEG_RAMP;
                m_next[k]   = {b_u_reg[k], 2'b00} + {1'b0, b_u_reg[k], 1'b0};
            end
            else if (b_u_reg[k] < HALF)
            begin
                seg_next[k] = SEG_Q;
            end
            else if (b_u_reg[k] < TWO_THIRDS)
            begin
                seg_next[k] = SEG_RAMP;
                m_next[k]   = {ramp_tail, 2'b00} + {1'b0, ramp_tail, 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c_seg_reg[k] <= seg_next[k];
                c_m_reg[k]   <= m_next[k];
            end
            c_p_reg    <= b_p_reg;
            c_q_reg    <= b_q_reg;
            c_span_reg <= b_span_reg;
            c_l_reg    <= b_l_reg;
            c_grey_reg <= b_grey_reg;
        end
    end

    // stage d: ramp products
    logic [PW-1:0] d_prod_reg [3];
    seg_t          d_seg_reg  [3];
    logic [W-1:0]  d_p_reg, d_q_reg, d_l_reg;
    logic          d_grey_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_prod_reg[k] <= {{MW{1'b0}}, c_span_reg} * {{W{1'b0}}, c_m_reg[k]};
                d_seg_reg[k]  <= c_seg_reg[k];
            end
            d_p_reg    <= c_p_reg;
            d_q_reg    <= c_q_reg;
            d_l_reg    <= c_l_reg;
            d_grey_reg <= c_grey_reg;
        end
    end

    // stage e: channel values
    logic [MW:0]  v_full [3];
    logic [W-1:0] v_next [3];
    logic [W-1:0] ch_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            case (d_seg_reg[k])
                SEG_RAMP: v_full[k] = {{(MW+1-W){1'b0}}, d_p_reg}
                                      + d_prod_reg[k][PW-1:FRAC_BITS];
                SEG_Q:    v_full[k] = {{(MW+1-W){1'b0}}, d_q_reg};
                default:  v_full[k] = {{(MW+1-W){1'b0}}, d_p_reg};
            endcase
            if (d_grey_reg)
            begin
                v_next[k] = d_l_reg;
            end
            else
            begin
                v_next[k] = (v_full[k] > {{(MW+1-W){1'b0}}, ONE}) ? ONE : v_full[k][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ch_reg[k] <= v_next[k];
            end
        end
    end

    assign red   = ch_reg[0];
    assign green = ch_reg[1];
    assign blue  = ch_reg[2];

endmodule

// ----- rtl/core/rgb_hsl_color_converter.sv -----
// Converts one pixel per clock between RGB and HSL; the direction register picks the mode
// (0: RGB to HSL, 1: HSL to RGB) and alpha rides along untouched. The pipeline depth
// is set by the two restoring dividers of the RGB-to-HSL path, which resolve one quotient
// bit per pipeline stage, plus the reciprocal multiply for the hue's divide by six.
// A new beat is taken every cycle while the output side takes beats; when the output stalls
// the whole pipeline holds. Write the direction only while no pixel is in flight.
module rgb_hsl_color_converter
#(
    parameter int CHANNEL_BITS = 8,
    parameter int FRAC_BITS    = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [rhc_pkg::FIELD_W-1:0] chan_first,
    input  logic [rhc_pkg::FIELD_W-1:0] chan_second,
    input  logic [rhc_pkg::FIELD_W-1:0] chan_third,
    input  logic [rhc_pkg::FIELD_W-1:0] alpha_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [rhc_pkg::FIELD_W-1:0] res_first,
    output logic [rhc_pkg::FIELD_W-1:0] res_second,
    output logic [rhc_pkg::FIELD_W-1:0] res_third,
    output logic [rhc_pkg::FIELD_W-1:0] alpha_out
);

    import rhc_pkg::*;

    localparam int W       = FRAC_BITS + 1;
    localparam int CB      = CHANNEL_BITS;
    localparam int XW      = (CB > FIELD_W) ? CB : FIELD_W;
    localparam int REP     = FRAC_BITS / CB + 1;
    localparam int LAT_HSL = FRAC_BITS + 6;
    localparam int LAT_RGB = 5;
    localparam int DLY     = LAT_HSL - LAT_RGB;
    localparam logic [W-1:0]  ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [CB-1:0] CMAX = '1;

    dir_t direction_reg;
    logic adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_RGB2HSL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            direction_reg <= dir_t'(cfg_data);
        end
    end

    // input channels to fractions: c / CMAX is the channel repeated in binary
    logic [FIELD_W-1:0] chan_in [3];
    logic [XW-1:0]      cx;
    logic [CB-1:0]      cc;
    logic [REP*CB-1:0]  rep;
    logic [W-1:0]       frac [3];

    assign chan_in[0] = chan_first;
    assign chan_in[1] = chan_second;
    assign chan_in[2] = chan_third;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cx  = XW'(chan_in[k]);
            cc  = (cx > XW'(CMAX)) ? CMAX : cx[CB-1:0];
            rep = {REP{cc}};
            frac[k] = (cc == CMAX) ? ONE : {1'b0, rep[REP*CB-1 -: FRAC_BITS]};
        end
    end

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    logic [W-1:0] hsl_h, hsl_s, hsl_l;
    logic [W-1:0] rgb_r, rgb_g, rgb_b;

    rhc_to_hsl #(.FRAC_BITS(FRAC_BITS)) u_to_hsl
    (
        .clk   (clk),
        .en    (adv),
        .red   (frac[0]),
        .green (frac[1]),
        .blue  (frac[2]),
        .hue   (hsl_h),
        .sat   (hsl_s),
        .lig   (hsl_l)
    );

    rhc_to_rgb #(.FRAC_BITS(FRAC_BITS)) u_to_rgb
    (
        .clk   (clk),
        .en    (adv),
        .hue   (frac[0]),
        .sat   (frac[1]),
        .lig   (frac[2]),
        .red   (rgb_r),
        .green (rgb_g),
        .blue  (rgb_b)
    );

    // line up the shorter path, alpha and the valid bits
    logic [3*W-1:0]     rgbd_reg  [DLY];
    logic [FIELD_W-1:0] alpha_reg [LAT_HSL];
    logic [LAT_HSL-1:0] vld_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rgbd_reg[0]  <= {rgb_r, rgb_g, rgb_b};
            alpha_reg[0] <= alpha_in;
            for (int i = 1; i < DLY; i++)
            begin
                rgbd_reg[i] <= rgbd_reg[i-1];
            end
            for (int i = 1; i < LAT_HSL; i++)
            begin
                alpha_reg[i] <= alpha_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT_HSL-2:0], in_valid};
        end
    end

    // output stage: mode select and fraction to channel, floor(v * CMAX)
    logic [W-1:0]    sel_v [3];
    logic [W+CB-1:0] scaled;
    logic [FIELD_W-1:0] res_next [3];
    logic               out_valid_reg;
    logic [FIELD_W-1:0] res_reg [3];
    logic [FIELD_W-1:0] alpha_out_reg;

    always_comb
    begin
        if (direction_reg == DIR_HSL2RGB)
        begin
            sel_v[0] = rgbd_reg[DLY-1][3*W-1 -: W];
            sel_v[1] = rgbd_reg[DLY-1][2*W-1 -: W];
            sel_v[2] = rgbd_reg[DLY-1][W-1:0];
        end
        else
        begin
            sel_v[0] = hsl_h;
            sel_v[1] = hsl_s;
            sel_v[2] = hsl_l;
        end
        for (int k = 0; k < 3; k++)
        begin
            scaled      = {sel_v[k], {CB{1'b0}}} - (W+CB)'(sel_v[k]);
            res_next[k] = FIELD_W'(scaled[W+CB-1:FRAC_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[LAT_HSL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                res_reg[k] <= res_next[k];
            end
            alpha_out_reg <= alpha_reg[LAT_HSL-1];
        end
    end

    assign out_valid  = out_valid_reg;
    assign res_first  = res_reg[0];
    assign res_second = res_reg[1];
    assign res_third  = res_reg[2];
    assign alpha_out  = alpha_out_reg;

endmodule

// ----- sim/rgb_hsl_color_converter_tb.sv -----
// testbench for the rgb/hsl color converter: random and directed pixels checked by a scoreboard
`timescale 1ns / 100ps

class pixel_scoreboard;
    localparam longint ONE        = 64'd65536;
    localparam longint SIXTH      = ONE / 6;
    localparam longint THIRD      = ONE / 3;
    localparam longint HALF       = ONE / 2;
    localparam longint TWO_THIRDS = (2 * ONE) / 3;

    rhc_pkg::dir_t mode;
    logic [31:0]   pending[$];
    int            errors;
    int            checked;

    function new();
        mode    = rhc_pkg::DIR_RGB2HSL;
        errors  = 0;
        checked = 0;
    endfunction

    function longint frac_of(logic [7:0] c);
        return (longint'(c) << 16) / 255;
    endfunction

    function logic [7:0] chan_of(longint v);
        longint o;
        if (v > ONE) v = ONE;
        o = (v * 255) >>> 16;
        if (o > 255) o = 255;
        return o[7:0];
    endfunction

    function longint ratio(longint num, longint den);
        return den == 0 ? 0 : (num << 16) / den;
    endfunction

    function longint hue_level(longint p, longint q, longint t);
        longint span;
        longint v;
        span = (q > p) ? q - p : 0;
        if (t < 0) t += ONE;
        else if (t > ONE) t -= ONE;
        if (t < 0) t = 0;
        if (t < SIXTH) v = p + ((span * 6 * t) >>> 16);
        else if (t < HALF) v = q;
        else if (t < TWO_THIRDS) v = p + ((span * (TWO_THIRDS - t) * 6) >>> 16);
        else v = p;
        return v > ONE ? ONE : v;
    endfunction

    function logic [31:0] convert(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3,
                                  logic [7:0] a);
        longint x, y, z, mx, mn, l, h, s, d, h6, q, p;
        int sel;
        logic [7:0] o1, o2, o3;
        x = frac_of(c1);
        y = frac_of(c2);
        z = frac_of(c3);
        if (mode == rhc_pkg::DIR_RGB2HSL) begin
            mx = x; mn = x; sel = 0; h = 0; s = 0;
            if (y > mx) begin mx = y; sel = 1; end
            if (z > mx) begin mx = z; sel = 2; end
            if (y < mn) mn = y;
            if (z < mn) mn = z;
            l = (mx + mn) >>> 1;
            if (mx != mn) begin
                d = mx - mn;
                if (l > HALF) s = (2 * ONE > mx + mn) ? ratio(d, 2 * ONE - mx - mn) : 0;
                else s = ratio(d, mx + mn);
                if (s > ONE) s = ONE;
                if (sel == 0)
                    h6 = (y >= z) ? ratio(y - z, d) : 6 * ONE - ratio(z - y, d);
                else if (sel == 1)
                    h6 = (z >= x) ? 2 * ONE + ratio(z - x, d) : 2 * ONE - ratio(x - z, d);
                else
                    h6 = (x >= y) ? 4 * ONE + ratio(x - y, d) : 4 * ONE - ratio(y - x, d);
                h = h6 / 6;
                if (h > ONE) h = ONE;
            end
            o1 = chan_of(h); o2 = chan_of(s); o3 = chan_of(l);
        end
        else if (y == 0) begin
            o1 = chan_of(z); o2 = o1; o3 = o1;
        end
        else begin
            if (z < HALF) q = (z * (ONE + y)) >>> 16;
            else q = z + y - ((z * y) >>> 16);
            if (q > ONE) q = ONE;
            p = (2 * z > q) ? 2 * z - q : 0;
            if (p > ONE) p = ONE;
            o1 = chan_of(hue_level(p, q, x + THIRD));
            o2 = chan_of(hue_level(p, q, x));
            o3 = chan_of(hue_level(p, q, x - THIRD));
        end
        return {o1, o2, o3, a};
    endfunction

    function void note_pixel(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3, logic [7:0] a);
        pending.push_back(convert(c1, c2, c3, a));
    endfunction

    function void check_pixel(logic [31:0] got);
        logic [31:0] want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected output beat %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        checked++;
        for (int i = 3; i >= 0; i--)
            if (want[i*8 +: 8] !== got[i*8 +: 8]) begin
                $display("%0t: field %0d mismatch, expected %0d actual %0d",
                         $time, 3 - i, want[i*8 +: 8], got[i*8 +: 8]);
                errors++;
            end
    endfunction
endclass

module rgb_hsl_color_converter_tb;
    localparam int WATCHDOG_LIMIT = 2000;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] chan_first, chan_second, chan_third, alpha_in;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] res_first, res_second, res_third, alpha_out;

    pixel_scoreboard board;
    int  idle_cycles;
    int  pixels_sent;
    int  mode_writes;
    bit  draining;

    rgb_hsl_color_converter u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .chan_first(chan_first), .chan_second(chan_second),
        .chan_third(chan_third), .alpha_in(alpha_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_first(res_first), .res_second(res_second),
        .res_third(res_third), .alpha_out(alpha_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // output side: random stalls, check on every accepted beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_pixel({res_first, res_second, res_third, alpha_out});
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (draining) begin
                out_ready = 1'b1;
            end
            else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
                out_ready = 1'b1;
                @(posedge clk);
                while (!out_valid) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_mode(rhc_pkg::dir_t m);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.mode = m;
        mode_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3, logic [7:0] a,
                              bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        chan_first  = c1;
        chan_second = c2;
        chan_third  = c3;
        alpha_in    = a;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_pixel(c1, c2, c3, a);
        pixels_sent++;
        @(negedge clk);
    endtask

    // called at a falling edge right after the last beat went in
    task automatic drain_pipeline();
        in_valid = 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic directed_pixels();
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 0);
        send_pixel(8'd255, 8'd0, 8'd0, 8'h5a, 0);
        send_pixel(8'd0, 8'd255, 8'd0, 8'ha5, 0);
        send_pixel(8'd0, 8'd0, 8'd255, 8'd1, 0);
        send_pixel(8'd255, 8'd255, 8'd0, 8'd2, 0);
        send_pixel(8'd255, 8'd0, 8'd255, 8'd3, 0);
        send_pixel(8'd128, 8'd128, 8'd128, 8'd4, 0);
        send_pixel(8'd10, 8'd200, 8'd250, 8'd5, 0);
    endtask

    initial
    begin
        rhc_pkg::dir_t m;
        int rnd_mode;
        board       = new();
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        in_valid    = 1'b0;
        chan_first  = '0;
        chan_second = '0;
        chan_third  = '0;
        alpha_in    = '0;
        idle_cycles = 0;
        pixels_sent = 0;
        mode_writes = 0;
        draining    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset mode first, then each mode with the corner pixels
        directed_pixels();
        drain_pipeline();
        write_mode(rhc_pkg::DIR_HSL2RGB);
        directed_pixels();
        send_pixel(8'd0, 8'd1, 8'd128, 8'd6, 0); // tiny saturation
        send_pixel(8'd42, 8'd255, 8'd127, 8'd7, 0);
        send_pixel(8'd170, 8'd255, 8'd200, 8'd8, 0);
        drain_pipeline();
        write_mode(rhc_pkg::DIR_RGB2HSL);

        for (int phase = 0; phase < 8; phase++)
        begin
            rnd_mode = phase % 2;
            m = rnd_mode ? rhc_pkg::DIR_HSL2RGB : rhc_pkg::DIR_RGB2HSL;
            write_mode(m);
            for (int i = 0; i < 110; i++)
                send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           (phase % 4 == 3));
            drain_pipeline();
        end

        draining = 1'b1;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d pixels in both directions with %0d mode writes, %0d checked",
                 pixels_sent, mode_writes, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
